@@ design/http_request_framer_top_defines.svh @@
// Assertion macros shared by the framer checker.
`ifndef HTTP_REQUEST_FRAMER_TOP_DEFINES_SVH
`define HTTP_REQUEST_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset.
`define HRF_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hrf_pkg.sv @@
// Types, match tables and character helpers for the HTTP request framer.
package hrf_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BODY,
    PH_SIZE_LINE,
    PH_CHUNK_DATA,
    PH_CHUNK_GAP,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    LV_SEARCH,
    LV_SKIP,
    LV_DIGITS,
    LV_DONE
  } lv_step_t;

  localparam int TE_KEY_N = 18;
  localparam int CH_VAL_N = 7;
  localparam int CL_KEY_N = 15;

  localparam logic [4:0] TE_KEY_LEN = 5'd18;
  localparam logic [4:0] CL_KEY_LEN = 5'd15;

  localparam logic [3:0] EV_SEARCH = 4'd0;
  localparam logic [3:0] EV_FIRST  = 4'd1;
  localparam logic [3:0] EV_LAST   = 4'd7;
  localparam logic [3:0] EV_FOUND  = 4'd8;
  localparam logic [3:0] EV_FAIL   = 4'd9;

  localparam logic [2:0] TERM_NONE = 3'd0;
  localparam logic [2:0] TERM_CR1  = 3'd1;
  localparam logic [2:0] TERM_LF1  = 3'd2;
  localparam logic [2:0] TERM_CR2  = 3'd3;
  localparam logic [2:0] TERM_DONE = 3'd4;

  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;

  localparam logic [7:0] TE_KEY [TE_KEY_N] = '{
    "t", "r", "a", "n", "s", "f", "e", "r", "-",
    "e", "n", "c", "o", "d", "i", "n", "g", ":"
  };
  localparam logic [7:0] CH_VAL [CH_VAL_N] = '{"c", "h", "u", "n", "k", "e", "d"};
  localparam logic [7:0] CL_KEY [CL_KEY_N] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
  };

  typedef struct packed {
    logic        framing_error;
    logic [31:0] body_length;
    logic [31:0] request_length;
    logic        chunked_mode;
    logic        request_end;
    logic [7:0]  out_byte;
  } result_t;

  function automatic logic [7:0] te_key_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < TE_KEY_LEN) begin
      ch = TE_KEY[idx];
    end
    return ch;
  endfunction

  function automatic logic [7:0] cl_key_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < CL_KEY_LEN) begin
      ch = CL_KEY[idx[3:0]];
    end
    return ch;
  endfunction

  function automatic logic [7:0] ch_val_char(input logic [3:0] step);
    logic [3:0] idx;
    logic [7:0] ch;
    idx = step - 4'd1;
    ch = 8'h00;
    if (step >= EV_FIRST && step <= EV_LAST) begin
      ch = CH_VAL[idx[2:0]];
    end
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b inside {[8'h41:8'h5A]}) begin
      c = b + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_dec(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

@@ design/hrf_in_stage.sv @@
// Input register: holds one byte transaction ahead of the framing logic.
module hrf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       space,
  output logic       fire,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_tready = !valid_r || space;
  assign accept    = in_tvalid && in_tready;
  assign fire      = valid_r && space;
  assign byte_q    = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
    end
  end

endmodule

@@ design/hrf_core.sv @@
// Framing state and per-byte next-state logic: header scan, body and chunk tracking.
module hrf_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  output hrf_pkg::result_t res
);
  import hrf_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
  localparam logic [LB-1:0] LEN_ZERO = '0;
  localparam logic [LB-1:0] LEN_TWO = LB'(2);

  phase_t        phase_r, phase_nxt;
  logic [2:0]    term_r, term_nxt;
  logic [4:0]    ek_r, ek_nxt;
  logic [3:0]    ev_r, ev_nxt;
  logic [4:0]    lk_r, lk_nxt;
  lv_step_t      lv_r, lv_nxt;
  logic [LB-1:0] decl_r, decl_nxt;
  logic [LB-1:0] accum_r, accum_nxt;
  logic          sl_digit_r, sl_digit_nxt;
  logic          sl_stop_r, sl_stop_nxt;
  logic          sl_cr_r, sl_cr_nxt;
  logic [LB-1:0] rem_r, rem_nxt;
  logic [LB-1:0] req_r, req_nxt;
  logic [LB-1:0] body_r, body_nxt;
  logic          chunked_r, chunked_nxt;
  logic          err_r, err_nxt;

  logic [7:0]    lc;
  logic          ws;
  logic          req_end;
  logic [LB-1:0] req_inc;
  logic [LB+3:0] dec_wide;
  logic [LB-1:0] dec_sat;
  logic [LB-1:0] hex_sat;
  logic [LB:0]   body_sum;
  logic [LB-1:0] body_sat;
  logic [LB-1:0] rem_dec;
  logic [63:0]   req_ext;
  logic [63:0]   body_ext;

  assign lc = to_lower(in_byte);
  assign ws = (lc == CHR_SP) || (lc == CHR_TAB);

  assign req_inc  = (&req_r) ? req_r : req_r + LB'(1);
  assign dec_wide = ({4'b0, decl_r} << 3) + ({4'b0, decl_r} << 1)
                  + {{LB{1'b0}}, in_byte[3:0]};
  assign dec_sat  = (|dec_wide[LB+3:LB]) ? LEN_MAX : dec_wide[LB-1:0];
  assign hex_sat  = (|accum_r[LB-1 -: 4]) ? LEN_MAX
                  : {accum_r[LB-5:0], hex_val(in_byte)};
  assign body_sum = {1'b0, body_r} + {1'b0, accum_r};
  assign body_sat = body_sum[LB] ? LEN_MAX : body_sum[LB-1:0];
  assign rem_dec  = (rem_r != LEN_ZERO) ? rem_r - LB'(1) : LEN_ZERO;

  always_comb begin
    phase_nxt    = phase_r;
    term_nxt     = term_r;
    ek_nxt       = ek_r;
    ev_nxt       = ev_r;
    lk_nxt       = lk_r;
    lv_nxt       = lv_r;
    decl_nxt     = decl_r;
    accum_nxt    = accum_r;
    sl_digit_nxt = sl_digit_r;
    sl_stop_nxt  = sl_stop_r;
    sl_cr_nxt    = sl_cr_r;
    rem_nxt      = rem_r;
    req_nxt      = req_inc;
    body_nxt     = body_r;
    chunked_nxt  = chunked_r;
    err_nxt      = err_r;
    req_end      = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (ev_r == EV_SEARCH) begin
          if (ek_r < TE_KEY_LEN && lc == te_key_char(ek_r)) begin
            ek_nxt = ek_r + 5'd1;
          end else begin
            ek_nxt = (lc == te_key_char(5'd0)) ? 5'd1 : 5'd0;
          end
          if (ek_nxt >= TE_KEY_LEN) begin
            ev_nxt = EV_FIRST;
          end
        end else if (ev_r >= EV_FIRST && ev_r <= EV_LAST) begin
          if (ev_r == EV_FIRST && ws) begin
            ev_nxt = ev_r;
          end else if (lc == ch_val_char(ev_r)) begin
            ev_nxt = ev_r + 4'd1;
          end else begin
            ev_nxt = EV_FAIL;
          end
        end

        case (lv_r)
          LV_SEARCH: begin
            if (lk_r < CL_KEY_LEN && lc == cl_key_char(lk_r)) begin
              lk_nxt = lk_r + 5'd1;
            end else begin
              lk_nxt = (lc == cl_key_char(5'd0)) ? 5'd1 : 5'd0;
            end
            if (lk_nxt >= CL_KEY_LEN) begin
              lv_nxt = LV_SKIP;
            end
          end
          LV_SKIP, LV_DIGITS: begin
            if (is_dec(lc)) begin
              decl_nxt = dec_sat;
              lv_nxt   = LV_DIGITS;
            end else if (!(lv_r == LV_SKIP && ws)) begin
              lv_nxt = LV_DONE;
            end
          end
          default: begin
            lv_nxt = lv_r;
          end
        endcase

        if ((term_r == TERM_NONE || term_r == TERM_LF1) && in_byte == CHR_CR) begin
          term_nxt = term_r + 3'd1;
        end else if ((term_r == TERM_CR1 || term_r == TERM_CR2) && in_byte == CHR_LF) begin
          term_nxt = term_r + 3'd1;
        end else begin
          term_nxt = (in_byte == CHR_CR) ? TERM_CR1 : TERM_NONE;
        end

        if (term_nxt >= TERM_DONE) begin
          if (ev_nxt == EV_FOUND) begin
            chunked_nxt  = 1'b1;
            phase_nxt    = PH_SIZE_LINE;
            accum_nxt    = LEN_ZERO;
            sl_digit_nxt = 1'b0;
            sl_stop_nxt  = 1'b0;
            sl_cr_nxt    = 1'b0;
          end else begin
            body_nxt = decl_nxt;
            if (decl_nxt == LEN_ZERO) begin
              req_end = 1'b1;
            end else begin
              rem_nxt   = decl_nxt;
              phase_nxt = PH_BODY;
            end
          end
        end
      end

      PH_BODY: begin
        rem_nxt = rem_dec;
        if (rem_dec == LEN_ZERO) begin
          req_end = 1'b1;
        end
      end

      PH_SIZE_LINE: begin
        if (sl_cr_r && in_byte == CHR_LF) begin
          if (!sl_digit_r) begin
            err_nxt = 1'b1;
          end
          if (accum_r == LEN_ZERO) begin
            rem_nxt   = LEN_TWO;
            phase_nxt = PH_TRAILER;
          end else begin
            body_nxt  = body_sat;
            rem_nxt   = accum_r;
            phase_nxt = PH_CHUNK_DATA;
          end
          accum_nxt    = LEN_ZERO;
          sl_digit_nxt = 1'b0;
          sl_stop_nxt  = 1'b0;
          sl_cr_nxt    = 1'b0;
        end else begin
          if (!sl_stop_r) begin
            if (is_hex(in_byte)) begin
              accum_nxt    = hex_sat;
              sl_digit_nxt = 1'b1;
            end else begin
              sl_stop_nxt = 1'b1;
            end
          end
          sl_cr_nxt = (in_byte == CHR_CR);
        end
      end

      PH_CHUNK_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == LEN_ZERO) begin
          rem_nxt   = LEN_TWO;
          phase_nxt = PH_CHUNK_GAP;
        end
      end

      PH_CHUNK_GAP: begin
        rem_nxt = rem_dec;
        if (rem_dec == LEN_ZERO) begin
          phase_nxt    = PH_SIZE_LINE;
          accum_nxt    = LEN_ZERO;
          sl_digit_nxt = 1'b0;
          sl_stop_nxt  = 1'b0;
          sl_cr_nxt    = 1'b0;
        end
      end

      default: begin
        rem_nxt = rem_dec;
        if (rem_dec == LEN_ZERO) begin
          req_end = 1'b1;
        end
      end
    endcase
  end

  assign req_ext  = 64'(req_nxt);
  assign body_ext = 64'(body_nxt);

  always_comb begin
    res.out_byte       = in_byte;
    res.request_end    = req_end;
    res.chunked_mode   = chunked_nxt;
    res.request_length = req_ext[31:0];
    res.body_length    = body_ext[31:0];
    res.framing_error  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && req_end)) begin
      phase_r    <= PH_HEADER;
      term_r     <= TERM_NONE;
      ek_r       <= 5'd0;
      ev_r       <= EV_SEARCH;
      lk_r       <= 5'd0;
      lv_r       <= LV_SEARCH;
      decl_r     <= LEN_ZERO;
      accum_r    <= LEN_ZERO;
      sl_digit_r <= 1'b0;
      sl_stop_r  <= 1'b0;
      sl_cr_r    <= 1'b0;
      rem_r      <= LEN_ZERO;
      req_r      <= LEN_ZERO;
      body_r     <= LEN_ZERO;
      chunked_r  <= 1'b0;
      err_r      <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      term_r     <= term_nxt;
      ek_r       <= ek_nxt;
      ev_r       <= ev_nxt;
      lk_r       <= lk_nxt;
      lv_r       <= lv_nxt;
      decl_r     <= decl_nxt;
      accum_r    <= accum_nxt;
      sl_digit_r <= sl_digit_nxt;
      sl_stop_r  <= sl_stop_nxt;
      sl_cr_r    <= sl_cr_nxt;
      rem_r      <= rem_nxt;
      req_r      <= req_nxt;
      body_r     <= body_nxt;
      chunked_r  <= chunked_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

@@ design/hrf_out_stage.sv @@
// Result register: holds one tagged byte until the downstream side takes it.
module hrf_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hrf_pkg::result_t res,
  output logic             space,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);
  import hrf_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.body_length, res_r.request_length, res_r.out_byte};
  assign out_tlast  = res_r.request_end;
  assign out_tuser  = {res_r.framing_error, res_r.chunked_mode};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ design/http_request_framer_top.sv @@
// Top level of the HTTP/1.1 request framer.
// Takes one byte per clock while the output is not stalled, from a stream of pipelined
// HTTP/1.1 requests and returns each byte tagged with an end-of-request mark (tlast), the
// chunked-framing and framing-error flags, and running request and body lengths. The
// sustained rate is one byte per cycle while out_tready is high; each byte goes from
// the input register to the result register, with all framing logic between the two.
// The header ends at the first CR LF CR LF; a transfer-encoding of chunked selects chunked
// framing, otherwise the content-length value sets the body size (zero if absent). Chunk
// size lines end at CR LF, with everything from the first non-hex byte ignored; an empty
// size line is taken as the last chunk and sets the error flag. Lengths saturate at
// 2^LENGTH_BITS - 1 and are reported in their low 32 bits.
module http_request_framer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [39:8] request_length, [71:40] body_length
  output logic        out_tlast,  // request_end
  output logic [1:0]  out_tuser   // [0] chunked_mode, [1] framing_error
);
  import hrf_pkg::*;

  logic       space;
  logic       fire;
  logic [7:0] byte_q;
  result_t    res;

  hrf_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .space     (space),
    .fire      (fire),
    .byte_q    (byte_q)
  );

  hrf_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (byte_q),
    .res     (res)
  );

  hrf_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ design/hrf_checker.sv @@
// Port-level assertions on the framer's result channel, bound to the top level.
`include "http_request_framer_top_defines.svh"

module hrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  `HRF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "stalled transaction dropped")
  `HRF_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled transaction changed")
  `HRF_ASSERT_SAME(a_err_chunked, out_tvalid && out_tuser[1], out_tuser[0], "framing error outside chunked framing")
  `HRF_ASSERT_SAME(a_req_len_nonzero, out_tvalid, out_tdata[39:8] != 32'd0, "request length of zero")
  `HRF_ASSERT_NEXT_RST(a_reset_clears, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind http_request_framer_top hrf_checker u_hrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
